FILE: sv/co2fc_pkg.sv
// ----------------------------------------------------------------------------
// co2fc_pkg
// Shared types and constants for the CO2 sensor response frame checker.
// ----------------------------------------------------------------------------
package co2fc_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int POS_W       = 4;
	localparam int CFG_IDX_W   = 2;

	localparam logic [POS_W-1:0] POS_FIRST = '0;
	localparam logic [POS_W-1:0] POS_CMD   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LOW   = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(FRAME_BYTES);

	localparam logic [7:0] HDR_START = 8'hFF;
	localparam logic [7:0] HDR_CMD   = 8'h86;

	localparam logic FUNC_BYTE    = 1'b0;
	localparam logic FUNC_TIMEOUT = 1'b1;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_BAD_HEADER   = 3'd1;
	localparam logic [2:0] ST_BAD_CHECKSUM = 3'd2;
	localparam logic [2:0] ST_RANGE        = 3'd3;
	localparam logic [2:0] ST_TIMEOUT      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_PPM_FLOOR   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PPM_CEILING = CFG_IDX_W'(1);

	localparam logic [15:0] PPM_FLOOR_RST   = 16'd300;
	localparam logic [15:0] PPM_CEILING_RST = 16'd5000;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] ppm;
		logic [2:0]  status;
	} result_t;

endpackage

FILE: sv/co2fc_frame.sv
// ----------------------------------------------------------------------------
// co2fc_frame
// Frame state and per-byte update: header check, running checksum, reading
// capture and the final status decision for one registered item.
// ----------------------------------------------------------------------------
module co2fc_frame
	import co2fc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  item_t       item,
	input  logic [15:0] ppm_floor,
	input  logic [15:0] ppm_ceiling,
	output result_t     result
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       sum_q, sum_d;
	logic             hdr_fail_q, hdr_fail_d;
	logic [7:0]       high_q, high_d;
	logic [7:0]       low_q, low_d;
	logic [15:0]      held_q, held_d;
	logic [POS_W-1:0] pos_eff;
	logic [7:0]       expect_sum;
	logic [15:0]      value;

	always_comb begin
		pos_d      = pos_q;
		sum_d      = sum_q;
		hdr_fail_d = hdr_fail_q;
		high_d     = high_q;
		low_d      = low_q;
		held_d     = held_q;
		result     = '{valid: 1'b0, ppm: held_q, status: ST_OK};
		pos_eff    = item.frame_start ? POS_FIRST : pos_q;
		expect_sum = 8'd0 - sum_q;
		value      = {high_q, low_q};
		if (item.func == FUNC_TIMEOUT) begin
			pos_d         = POS_IDLE;
			result.valid  = 1'b1;
			result.status = ST_TIMEOUT;
		end else if (pos_eff >= POS_IDLE) begin
			pos_d = pos_q;
		end else if (pos_eff == POS_FIRST) begin
			hdr_fail_d = (item.rx_byte != HDR_START);
			sum_d      = 8'd0;
			pos_d      = POS_CMD;
		end else if (pos_eff < POS_LAST) begin
			if (pos_eff == POS_CMD && item.rx_byte != HDR_CMD) begin
				hdr_fail_d = 1'b1;
			end
			if (pos_eff == POS_HIGH) begin
				high_d = item.rx_byte;
			end
			if (pos_eff == POS_LOW) begin
				low_d = item.rx_byte;
			end
			sum_d = sum_q + item.rx_byte;
			pos_d = pos_eff + POS_W'(1);
		end else begin
			pos_d        = POS_IDLE;
			result.valid = 1'b1;
			priority if (hdr_fail_q) begin
				result.status = ST_BAD_HEADER;
			end else if (expect_sum != item.rx_byte) begin
				result.status = ST_BAD_CHECKSUM;
			end else if (!(value > ppm_floor && value < ppm_ceiling)) begin
				result.status = ST_RANGE;
			end else begin
				result.status = ST_OK;
				held_d        = value;
				result.ppm    = value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_IDLE;
			sum_q      <= '0;
			hdr_fail_q <= 1'b0;
			high_q     <= '0;
			low_q      <= '0;
			held_q     <= '0;
		end else if (take) begin
			pos_q      <= pos_d;
			sum_q      <= sum_d;
			hdr_fail_q <= hdr_fail_d;
			high_q     <= high_d;
			low_q      <= low_d;
			held_q     <= held_d;
		end
	end

endmodule

FILE: sv/co2_sensor_frame_checker.sv
// ----------------------------------------------------------------------------
// co2_sensor_frame_checker
// Checks 9-byte CO2 sensor responses one byte per item and reports a status
// with the held ppm reading at the end of each frame or on a timeout.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and any result it
// yields is then loaded into the result register that drives the outputs.
// Throughput: one item per cycle; the input and result registers advance
// together whenever the result register is empty or being taken.
// Reset: arst_n clears the frame state, held reading and both limits to their
// defaults (300 and 5000) and empties both registers at once.
module co2_sensor_frame_checker
	import co2fc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          ppm,
	output logic [2:0]           status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	logic        valid_s1;
	item_t       item_s1;
	logic        go;
	result_t     result;
	logic        out_valid_q;
	logic [15:0] ppm_q;
	logic [2:0]  status_q;
	logic [15:0] ppm_floor_q;
	logic [15:0] ppm_ceiling_q;

	assign go        = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || go;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign ppm       = ppm_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_floor_q   <= PPM_FLOOR_RST;
			ppm_ceiling_q <= PPM_CEILING_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PPM_FLOOR) begin
				ppm_floor_q <= cfg_data;
			end
			if (cfg_index == REG_PPM_CEILING) begin
				ppm_ceiling_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{func: func, rx_byte: rx_byte, frame_start: frame_start};
		end
	end

	co2fc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (valid_s1 && go),
		.item        (item_s1),
		.ppm_floor   (ppm_floor_q),
		.ppm_ceiling (ppm_ceiling_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= valid_s1 && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go && valid_s1 && result.valid) begin
			ppm_q    <= result.ppm;
			status_q <= result.status;
		end
	end

endmodule

FILE: sv/co2fc_checker.sv
// ----------------------------------------------------------------------------
// co2fc_checker
// Port-level assertions for the CO2 sensor frame checker, bound to the top.
// ----------------------------------------------------------------------------
module co2fc_checker
	import co2fc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] ppm,
	input logic [2:0]  status,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ppm) && $stable(status))
		else $error("result changed while stalled");

	// With no result pending, the input side never stalls.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result register");

	// A good frame has a reading above the floor, so it cannot be zero.
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> ppm != 16'd0)
		else $error("good frame reported a zero reading");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind co2_sensor_frame_checker co2fc_checker u_co2fc_checker (.*);

FILE: tb/sv/co2_frame_audit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2_frame_audit
// Watches the byte, result and register channels of the CO2 frame checker.
// Every accepted byte item advances a private copy of the frame state. Each
// result that the copy predicts is queued and then compared field by field
// with the next result the block hands over.
// ----------------------------------------------------------------------------
module co2_frame_audit
	import co2fc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 func,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_start,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [15:0]          ppm,
	input  logic [2:0]           status,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic [15:0] ppm;
		logic [2:0]  status;
	} frame_report_t;

	frame_report_t    due_reports[$];
	logic [POS_W-1:0] position;
	logic [7:0]       byte_total;
	logic [7:0]       reading_hi;
	logic [7:0]       reading_lo;
	logic             header_bad;
	logic [15:0]      held_ppm;
	logic [15:0]      floor_ppm;
	logic [15:0]      ceiling_ppm;
	int               errors = 0;

	task automatic advance_frame(input logic f, input logic [7:0] b, input logic s);
		logic [15:0]   reading;
		frame_report_t report;
		if (f == FUNC_TIMEOUT) begin
			position = POS_IDLE;
			report.ppm = held_ppm;
			report.status = ST_TIMEOUT;
			due_reports.push_back(report);
			return;
		end
		if (s) begin
			position = POS_FIRST;
		end else if (position >= POS_IDLE) begin
			return;
		end
		if (position == POS_FIRST) begin
			header_bad = (b != HDR_START);
			byte_total = 8'd0;
			position = POS_CMD;
		end else if (position < POS_LAST) begin
			if (position == POS_CMD && b != HDR_CMD)
				header_bad = 1'b1;
			if (position == POS_HIGH)
				reading_hi = b;
			if (position == POS_LOW)
				reading_lo = b;
			byte_total = byte_total + b;
			position = position + POS_W'(1);
		end else begin
			reading = {reading_hi, reading_lo};
			if (header_bad) begin
				report.status = ST_BAD_HEADER;
			end else if (b != 8'(8'd0 - byte_total)) begin
				report.status = ST_BAD_CHECKSUM;
			end else if (!(reading > floor_ppm && reading < ceiling_ppm)) begin
				report.status = ST_RANGE;
			end else begin
				report.status = ST_OK;
				held_ppm = reading;
			end
			report.ppm = held_ppm;
			position = POS_IDLE;
			due_reports.push_back(report);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_report_t oldest;
		if (!arst_n) begin
			due_reports.delete();
			position = POS_IDLE;
			byte_total = 8'd0;
			reading_hi = 8'd0;
			reading_lo = 8'd0;
			header_bad = 1'b0;
			held_ppm = 16'd0;
			floor_ppm = PPM_FLOOR_RST;
			ceiling_ppm = PPM_CEILING_RST;
			mismatches <= errors;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: ppm %0d, status %0d",
						$time, ppm, status);
				end else begin
					oldest = due_reports.pop_front();
					if (ppm !== oldest.ppm) begin
						errors++;
						$display("%0t: ppm mismatch: expected %0d, actual %0d",
							$time, oldest.ppm, ppm);
					end
					if (status !== oldest.status) begin
						errors++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, oldest.status, status);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PPM_FLOOR)
					floor_ppm = cfg_data;
				else if (cfg_index == REG_PPM_CEILING)
					ceiling_ppm = cfg_data;
			end
			if (in_valid && in_ready)
				advance_frame(func, rx_byte, frame_start);
			mismatches <= errors;
			outstanding <= due_reports.size();
		end
	end

endmodule

FILE: tb/sv/tb_co2_sensor_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_co2_sensor_frame_checker
// Drives sensor response bytes, timeouts and limit writes into the frame
// checker. A short directed sequence is followed by random traffic under
// several limit settings; an audit module beside the block judges every
// result.
// ----------------------------------------------------------------------------
module tb_co2_sensor_frame_checker;
	import co2fc_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int RANDOM_PHASE    = 4;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 func;
	logic [7:0]           rx_byte;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_ready;
	logic [15:0]          ppm;
	logic [2:0]           status;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	int                   mismatches;
	int                   outstanding;
	int                   cycle_count = 0;
	bit                   idle_on;
	logic [15:0]          cur_floor;
	logic [15:0]          cur_ceiling;

	logic [15:0] floor_plan [PHASES]   = '{16'd0, 16'd1000, 16'hFFFF, 16'd0, 16'd0, 16'd300};
	logic [15:0] ceiling_plan [PHASES] = '{16'hFFFF, 16'd1001, 16'd0, 16'd2, 16'd0, 16'd5000};

	co2_sensor_frame_checker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ppm         (ppm),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	co2_frame_audit u_audit (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ppm         (ppm),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("co2_sensor_frame_checker regression: fail");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(input logic f, input logic [7:0] b, input logic s);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		rx_byte <= b;
		frame_start <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_frame(input logic [7:0] lead, input logic [7:0] cmd,
		input logic [15:0] reading, input bit sum_ok, input int len);
		logic [7:0] frame_data [FRAME_BYTES];
		logic [7:0] acc;
		frame_data[0] = lead;
		frame_data[1] = cmd;
		frame_data[2] = reading[15:8];
		frame_data[3] = reading[7:0];
		for (int k = 4; k < FRAME_BYTES - 1; k++)
			frame_data[k] = 8'($urandom_range(0, 255));
		acc = 8'd0;
		for (int k = 1; k < FRAME_BYTES - 1; k++)
			acc = acc + frame_data[k];
		frame_data[FRAME_BYTES - 1] = 8'd0 - acc;
		if (!sum_ok)
			frame_data[FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
		for (int k = 0; k < len; k++)
			send_item(FUNC_BYTE, frame_data[k], k == 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_reading();
		int span;
		span = int'(cur_ceiling) - int'(cur_floor);
		case ($urandom_range(0, 9))
			0: return cur_floor;
			1: return cur_floor + 16'd1;
			2: return cur_ceiling - 16'd1;
			3: return cur_ceiling;
			4: return 16'h0000;
			5: return 16'hFFFF;
			6: return cur_floor - 16'd1;
			7: return cur_ceiling + 16'd1;
			default: begin
				if (span >= 2)
					return 16'(int'(cur_floor) + 1 + int'($urandom_range(0, span - 2)));
				return 16'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	task automatic run_traffic(input int quota);
		int         sent;
		int         kind;
		int         len;
		logic [7:0] lead;
		logic [7:0] cmd;
		logic       f;
		logic       s;
		sent = 0;
		while (sent < quota) begin
			kind = $urandom_range(0, 99);
			lead = HDR_START;
			cmd = HDR_CMD;
			if ($urandom_range(0, 9) == 0)
				lead = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0)
				cmd = 8'($urandom_range(0, 255));
			if (kind < 75) begin
				send_frame(lead, cmd, pick_reading(), $urandom_range(0, 4) != 0, FRAME_BYTES);
				sent += FRAME_BYTES;
			end else if (kind < 92) begin
				len = $urandom_range(1, FRAME_BYTES - 1);
				send_frame(lead, cmd, pick_reading(), 1'b1, len);
				sent += len;
				if (kind >= 84) begin
					send_item(FUNC_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					sent++;
				end
			end else begin
				f = 1'($urandom_range(0, 1));
				s = 1'($urandom_range(0, 1));
				send_item(f, 8'($urandom_range(0, 255)), s);
				if (f || s)
					sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_BYTE;
		rx_byte = 8'd0;
		frame_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PPM_FLOOR;
		cfg_data = 16'd0;
		idle_on = 1'b1;
		cur_floor = PPM_FLOOR_RST;
		cur_ceiling = PPM_CEILING_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A good frame, a stray byte while idle, a timeout while idle, a frame
		// restarted in the middle, a bad header hiding a bad checksum, and a bad
		// checksum hiding an out of range reading.
		send_frame(HDR_START, HDR_CMD, 16'd400, 1'b1, FRAME_BYTES);
		send_item(FUNC_BYTE, 8'h5A, 1'b0);
		send_item(FUNC_TIMEOUT, 8'hFF, 1'b1);
		send_frame(HDR_START, HDR_CMD, 16'd1234, 1'b1, 2);
		send_frame(8'h00, HDR_CMD, 16'd700, 1'b0, FRAME_BYTES);
		send_frame(HDR_START, HDR_CMD, 16'hFFFF, 1'b0, FRAME_BYTES);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p == RANDOM_PHASE) begin
				cur_floor = 16'($urandom_range(0, 60000));
				cur_ceiling = cur_floor + 16'($urandom_range(0, 5000));
			end else begin
				cur_floor = floor_plan[p];
				cur_ceiling = ceiling_plan[p];
			end
			cfg_write(REG_PPM_FLOOR, cur_floor);
			cfg_write(REG_PPM_CEILING, cur_ceiling);
			cfg_valid <= 1'b0;
			idle_on = (p != PHASES - 1);
			run_traffic(ITEMS_PER_PHASE);
		end
		settle();

		if (mismatches == 0)
			$display("co2_sensor_frame_checker regression: pass");
		else
			$display("co2_sensor_frame_checker regression: fail");
		$finish;
	end

endmodule
